// File: rtl/mas_pkg.sv
package mas_pkg;

   // mode register codes (code 3 behaves as pass through)
   localparam int          MODE_W    = 2;
   localparam logic [1:0]  MODE_PASS = 2'd0;
   localparam logic [1:0]  MODE_SMA  = 2'd1;
   localparam logic [1:0]  MODE_EMA  = 2'd2;

   // configuration register map
   localparam int          CSR_IDX_W  = 2;
   localparam int          CSR_DATA_W = 7;
   localparam logic [1:0]  CSR_MODE   = 2'd0;
   localparam logic [1:0]  CSR_WLEN   = 2'd1;

   // window length register
   localparam int          WLEN_W     = 7;
   localparam logic [6:0]  WLEN_RESET = 7'd4;

   // fixed-point constants for the exponential gain
   localparam int          FRAC_BITS   = 16;
   localparam int          ALPHA_W     = 17;
   localparam int          ALPHA_NUM   = 131072;
   localparam int          ALPHA_NUM_W = 18;
   localparam int          ROUND_HALF  = 32768;

endpackage

// File: rtl/mas_ram.sv
module mas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mas_divider.sv
module mas_divider #(
   parameter int DVD_W = 38,
   parameter int DVS_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

   logic             active_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] dvs_ff;

   logic [DVS_W:0]   rem_shift;
   logic             fits;
   logic [DVS_W:0]   rem_diff;
   logic [DVS_W-1:0] rem_in;

   // one restoring step: shift in the next dividend bit, trial subtract
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      rem_diff  = rem_shift - {1'b0, dvs_ff};
      rem_in    = fits ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
   end

   // iteration control, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            active_ff <= 1'b1;
            cnt_ff    <= '0;
            rem_ff    <= '0;
            quo_ff    <= dividend;
            dvs_ff    <= divisor;
         end else if (active_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DVD_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/moving_average_smoother.sv
// channel  direction  handshake              payload
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata
// req      in         req_valid / req_ready  req_sample, req_advance, req_restart
// rsp      out        rsp_valid / rsp_ready  rsp_smoothed, rsp_fill_count
//
// one word in flight at a time; req_ready is low from acceptance until the result is taken
// pass through and exponential priming words: the result is registered at acceptance,
//   averaging priming words first go through the push step
// averaging words: the bit-serial divider, preceded by a push on advance and by a drop
//   before that when a full window gives up its oldest word; the divider also computes
//   the exponential gain
// exponential words: divider, then one multiply and round
// synchronous active-high reset; window memory is not cleared, it is filled before read
// a stalled result holds the block; csr writes are taken only while idle, ahead of a word
module moving_average_smoother #(
   parameter int MAX_WINDOW   = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mas_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mas_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   input  logic                                req_advance,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]      rsp_smoothed,
   output logic [$clog2(MAX_WINDOW+1)-1:0]     rsp_fill_count
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W  = $clog2(MAX_WINDOW);
   localparam int SUM_W  = SW + PTR_W;
   localparam int DVS_W  = $clog2(MAX_WINDOW + 2);
   localparam int DVD_W  = (SUM_W > mas_pkg::ALPHA_NUM_W) ? SUM_W : mas_pkg::ALPHA_NUM_W;
   localparam int DIFF_W = SW + 1;
   localparam int PROD_W = DIFF_W + mas_pkg::ALPHA_W + 1;
   localparam int CMP_W  = (CNT_W > mas_pkg::WLEN_W) ? CNT_W : mas_pkg::WLEN_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DROP,
      S_PUSH,
      S_DIV,
      S_MUL,
      S_ROUND,
      S_RESP
   } state_type;

   state_type                        state_ff;
   logic [mas_pkg::MODE_W-1:0]       mode_ff;
   logic [mas_pkg::WLEN_W-1:0]       wlen_ff;
   logic [PTR_W-1:0]                 wp_ff;
   logic [CNT_W-1:0]                 held_ff;
   logic signed [SUM_W-1:0]          sum_ff;
   logic signed [SW-1:0]             prev_ff;
   logic                             primed_ff;
   logic                             div_start_ff;
   logic                             prime_ff;
   logic                             adv_ff;
   logic signed [SW-1:0]             sample_ff;
   logic signed [DIFF_W-1:0]         diff_ff;
   logic [mas_pkg::ALPHA_W-1:0]      alpha_ff;
   logic signed [PROD_W-1:0]         prod_ff;
   logic signed [SW-1:0]             y_ff;

   logic                             csr_write;
   logic                             csr_listed;
   logic                             primed_eff;
   logic [CMP_W-1:0]                 wlen_ext;
   logic [CNT_W-1:0]                 n_eff;
   logic                             held_full;
   logic [CNT_W-1:0]                 wp_next;
   logic [PTR_W-1:0]                 wp_in;
   logic [DVS_W-1:0]                 n_plus1;
   logic                             sum_neg;
   logic [SUM_W-1:0]                 sum_mag;
   logic [DVD_W-1:0]                 div_dvd;
   logic [DVS_W-1:0]                 div_dvs;
   logic                             div_done;
   logic [DVD_W-1:0]                 div_quo;
   logic [SW-1:0]                    mean;
   logic signed [PROD_W-1:0]         rnd_sum;
   logic signed [PROD_W-1:0]         rnd_shift;
   logic [SW-1:0]                    ram_rd_data;

   // handshakes
   assign csr_ready  = (state_ff == S_IDLE);
   assign csr_write  = csr_valid & csr_ready;
   assign csr_listed = (csr_index == mas_pkg::CSR_MODE) || (csr_index == mas_pkg::CSR_WLEN);
   assign req_ready  = (state_ff == S_IDLE) & ~csr_valid;
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_smoothed   = y_ff;
   assign rsp_fill_count = held_ff;

   // effective window length: 0 acts as 1, clipped at MAX_WINDOW
   always_comb begin
      wlen_ext = CMP_W'(wlen_ff);
      if (wlen_ext == '0) begin
         n_eff = CNT_W'(1);
      end else if (wlen_ext > CMP_W'(MAX_WINDOW)) begin
         n_eff = CNT_W'(MAX_WINDOW);
      end else begin
         n_eff = CNT_W'(wlen_ext);
      end
   end

   // window bookkeeping
   assign primed_eff = primed_ff & ~req_restart;
   assign held_full  = (held_ff == n_eff);
   assign wp_next    = CNT_W'(wp_ff) + 1'b1;
   assign wp_in      = (wp_next == n_eff) ? '0 : wp_next[PTR_W-1:0];

   // divider operands: mean magnitude, or gain numerator over N+1
   always_comb begin
      n_plus1 = DVS_W'(n_eff) + 1'b1;
      sum_neg = sum_ff[SUM_W-1];
      sum_mag = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      if (mode_ff == mas_pkg::MODE_SMA) begin
         div_dvd = DVD_W'(sum_mag);
         div_dvs = DVS_W'(held_ff);
      end else begin
         div_dvd = DVD_W'(mas_pkg::ALPHA_NUM) + DVD_W'(n_plus1 >> 1);
         div_dvs = n_plus1;
      end
      mean = sum_neg ? (-div_quo[SW-1:0]) : div_quo[SW-1:0];
   end

   // gain product rounded to nearest, ties up
   always_comb begin
      rnd_sum   = prod_ff + PROD_W'(mas_pkg::ROUND_HALF);
      rnd_shift = rnd_sum >>> mas_pkg::FRAC_BITS;
   end

   mas_divider #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   mas_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_WINDOW)
   ) u_window (
      .clock   (clock),
      .wr_en   (state_ff == S_PUSH),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_addr (wp_ff),
      .rd_data (ram_rd_data)
   );

   // sequencer with filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= mas_pkg::MODE_PASS;
         wlen_ff      <= mas_pkg::WLEN_RESET;
         wp_ff        <= '0;
         held_ff      <= '0;
         sum_ff       <= '0;
         prev_ff      <= '0;
         primed_ff    <= 1'b0;
         div_start_ff <= 1'b0;
         prime_ff     <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (csr_write) begin
                  if (csr_index == mas_pkg::CSR_MODE) begin
                     mode_ff <= csr_wdata[mas_pkg::MODE_W-1:0];
                  end else if (csr_index == mas_pkg::CSR_WLEN) begin
                     wlen_ff <= csr_wdata[mas_pkg::WLEN_W-1:0];
                  end
                  if (csr_listed) begin
                     wp_ff     <= '0;
                     held_ff   <= '0;
                     sum_ff    <= '0;
                     prev_ff   <= '0;
                     primed_ff <= 1'b0;
                  end
               end else if (req_valid) begin
                  sample_ff <= req_sample;
                  adv_ff    <= req_advance;
                  diff_ff   <= DIFF_W'(req_sample) - DIFF_W'(prev_ff);
                  y_ff      <= req_sample;
                  primed_ff <= primed_eff;
                  prime_ff  <= 1'b0;
                  case (mode_ff)
                     mas_pkg::MODE_SMA: begin
                        if (!primed_eff) begin
                           wp_ff     <= '0;
                           held_ff   <= '0;
                           sum_ff    <= '0;
                           primed_ff <= 1'b1;
                           prime_ff  <= 1'b1;
                           state_ff  <= S_PUSH;
                        end else if (req_advance) begin
                           state_ff <= held_full ? S_DROP : S_PUSH;
                        end else if (held_ff == '0) begin
                           state_ff <= S_RESP;
                        end else begin
                           div_start_ff <= 1'b1;
                           state_ff     <= S_DIV;
                        end
                     end
                     mas_pkg::MODE_EMA: begin
                        if (!primed_eff) begin
                           prev_ff   <= req_sample;
                           primed_ff <= 1'b1;
                           state_ff  <= S_RESP;
                        end else begin
                           div_start_ff <= 1'b1;
                           state_ff     <= S_DIV;
                        end
                     end
                     default: begin
                        state_ff <= S_RESP;
                     end
                  endcase
               end
            end
            // full window: oldest word sits at the write pointer
            S_DROP: begin
               sum_ff   <= sum_ff - SUM_W'($signed(ram_rd_data));
               held_ff  <= held_ff - 1'b1;
               state_ff <= S_PUSH;
            end
            S_PUSH: begin
               sum_ff  <= sum_ff + SUM_W'(sample_ff);
               wp_ff   <= wp_in;
               held_ff <= held_ff + 1'b1;
               if (prime_ff) begin
                  state_ff <= S_RESP;
               end else begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  if (mode_ff == mas_pkg::MODE_SMA) begin
                     y_ff     <= $signed(mean);
                     state_ff <= S_RESP;
                  end else begin
                     alpha_ff <= div_quo[mas_pkg::ALPHA_W-1:0];
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= diff_ff * $signed({1'b0, alpha_ff});
               state_ff <= S_ROUND;
            end
            S_ROUND: begin
               y_ff     <= prev_ff + $signed(rnd_shift[SW-1:0]);
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  if (adv_ff) begin
                     prev_ff <= y_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // window count never exceeds the effective length
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= n_eff)
      else $error("window count above window length");

   // write pointer stays inside the window
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(wp_ff) < n_eff)
      else $error("write pointer outside window");

   // the input is not ready right after a word is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input ready right after acceptance");

   // divider finishes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider done outside divide state");

   // averaging divide never sees an empty window
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (div_start_ff && (mode_ff == mas_pkg::MODE_SMA)) |-> (held_ff != '0))
      else $error("mean divide with empty window");

endmodule

// File: dv/tb_moving_average_smoother.sv
`timescale 1ns / 1ps

module tb_moving_average_smoother;

   localparam int MAX_WIN      = 64;
   localparam int SW           = 32;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_TAIL   = 60;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_WORDS = 750;

   // indexes past the register map, writes there must leave the state alone
   localparam logic [mas_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [mas_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   // mode code with no function of its own, behaves as pass through
   localparam logic [mas_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;

   localparam logic signed [SW-1:0] S_MIN = 32'sh8000_0000;
   localparam logic signed [SW-1:0] S_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic signed [SW-1:0] smoothed;
      logic [6:0]           fill;
   } smoothed_word_type;

   // predicts the smoothed word for every accepted sample and checks results in order
   class smoothing_scoreboard;
      logic [mas_pkg::MODE_W-1:0] mode_reg;
      logic [mas_pkg::WLEN_W-1:0] wlen_reg;
      logic signed [SW-1:0]       window_mem [MAX_WIN];
      int                         wr_ptr;
      int                         held;
      longint                     run_sum;
      longint                     prev_out;
      bit                         primed;
      int                         errors;
      smoothed_word_type          pending_outputs [$];

      function new();
         mode_reg = mas_pkg::MODE_PASS;
         wlen_reg = mas_pkg::WLEN_RESET;
         foreach (window_mem[i]) window_mem[i] = '0;
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         wr_ptr   = 0;
         held     = 0;
         run_sum  = 0;
         prev_out = 0;
         primed   = 1'b0;
      endfunction

      function int pending();
         return pending_outputs.size();
      endfunction

      function void write_reg(logic [mas_pkg::CSR_IDX_W-1:0]  idx,
                              logic [mas_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            mas_pkg::CSR_MODE: begin
               mode_reg = data[mas_pkg::MODE_W-1:0];
               clear_state();
            end
            mas_pkg::CSR_WLEN: begin
               wlen_reg = data;
               clear_state();
            end
            default: ;
         endcase
      endfunction

      // full window drops its oldest entry before the new one goes in
      function void push_window(logic signed [SW-1:0] s, int n);
         int oldest;
         if (held >= n) begin
            oldest = (wr_ptr + n - held) % n;
            run_sum -= longint'(window_mem[oldest]);
            held--;
         end
         window_mem[wr_ptr % n] = s;
         run_sum += longint'(s);
         wr_ptr = (wr_ptr + 1) % n;
         held++;
      endfunction

      function void note_sample(logic signed [SW-1:0] s, bit adv, bit rs);
         int                n;
         longint            y;
         longint            alpha;
         longint            prod;
         smoothed_word_type w;
         // zero acts as one, anything past the window depth acts as the depth
         if (wlen_reg == 0) n = 1;
         else if (wlen_reg > MAX_WIN) n = MAX_WIN;
         else n = wlen_reg;
         y = s;
         if (rs) primed = 1'b0;
         if (mode_reg == mas_pkg::MODE_SMA) begin
            if (!primed) begin
               wr_ptr  = 0;
               held    = 0;
               run_sum = 0;
               push_window(s, n);
               primed = 1'b1;
            end else begin
               if (adv) push_window(s, n);
               if (held != 0) y = run_sum / longint'(held);
            end
         end else if (mode_reg == mas_pkg::MODE_EMA) begin
            if (!primed) begin
               prev_out = s;
               primed   = 1'b1;
            end else begin
               // gain 2/(N+1) in Q1.16, product rounded half up
               alpha = (mas_pkg::ALPHA_NUM + (n + 1) / 2) / (n + 1);
               prod  = (longint'(s) - prev_out) * alpha;
               y     = prev_out + ((prod + mas_pkg::ROUND_HALF) >>> mas_pkg::FRAC_BITS);
            end
         end
         if (adv) prev_out = y;
         w.smoothed = y[SW-1:0];
         w.fill     = held[6:0];
         pending_outputs.push_back(w);
      endfunction

      function void check_result(logic signed [SW-1:0] smoothed, logic [6:0] fill);
         smoothed_word_type w;
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual smoothed %0d fill %0d",
                     $time, smoothed, fill);
            errors++;
            return;
         end
         w = pending_outputs.pop_front();
         if (smoothed !== w.smoothed) begin
            $display("%0t: smoothed mismatch, expected %0d, actual %0d",
                     $time, w.smoothed, smoothed);
            errors++;
         end
         if (fill !== w.fill) begin
            $display("%0t: fill_count mismatch, expected %0d, actual %0d",
                     $time, w.fill, fill);
            errors++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [mas_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [mas_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                            req_valid;
   logic                            req_ready;
   logic signed [SW-1:0]            req_sample;
   logic                            req_advance;
   logic                            req_restart;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic signed [SW-1:0]            rsp_smoothed;
   logic [6:0]                      rsp_fill_count;

   smoothing_scoreboard sb = new();
   bit                  calm;
   bit                  hold_req;
   int                  cycle_count;

   moving_average_smoother #(
      .MAX_WINDOW  (MAX_WIN),
      .SAMPLE_WIDTH(SW)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .req_advance   (req_advance),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_smoothed  (rsp_smoothed),
      .rsp_fill_count(rsp_fill_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // idle lengths: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_smoothed, rsp_fill_count);
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : receiver
      int stall_left;
      bit hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            stall_left = HOLD_CYCLES;
            hold_done  = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // offer one sample word, called and returning at a falling edge
   task automatic send_word(input logic signed [SW-1:0] s, input bit adv, input bit rs);
      req_sample  <= s;
      req_advance <= adv;
      req_restart <= rs;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(s, adv, rs);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   // stop offering and wait for every expected word
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic csr_write(input logic [mas_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [mas_pkg::CSR_DATA_W-1:0] data);
      drain_results();
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : stimulus
      int                         sent;
      int                         phase;
      int                         len;
      int                         r;
      logic [mas_pkg::MODE_W-1:0] m;
      logic [mas_pkg::WLEN_W-1:0] wl;
      logic signed [SW-1:0]       s;
      logic signed [SW-1:0]       last_sample;
      bit                         adv;
      bit                         rs;

      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_valid   = 1'b0;
      req_sample  = '0;
      req_advance = 1'b0;
      req_restart = 1'b0;
      calm        = 1'b0;
      hold_req    = 1'b0;
      last_sample = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // pass through with reset settings, field extremes
      send_word(S_MIN, 1'b1, 1'b0);
      send_word(S_MAX, 1'b0, 1'b1);
      send_word('0, 1'b1, 1'b1);
      send_word(-1, 1'b0, 1'b0);

      // averaging over four: priming, fill, full window, hold, restart
      csr_write(mas_pkg::CSR_MODE, {5'd0, mas_pkg::MODE_SMA});
      repeat (5) send_word(S_MAX, 1'b1, 1'b0);
      send_word(S_MIN, 1'b0, 1'b0);
      send_word(S_MIN, 1'b1, 1'b0);
      send_word(32'sh0001_8000, 1'b1, 1'b1);
      // write past the register map keeps the window
      csr_write(CSR_SPARE_A, 7'h7f);
      send_word(S_MIN, 1'b1, 1'b0);
      csr_write(mas_pkg::CSR_WLEN, 7'd1);
      send_word(S_MAX, 1'b1, 1'b0);
      send_word(S_MIN, 1'b1, 1'b0);

      // exponential, length zero acts as one
      csr_write(mas_pkg::CSR_MODE, {5'd0, mas_pkg::MODE_EMA});
      csr_write(mas_pkg::CSR_WLEN, 7'd0);
      send_word(S_MIN, 1'b1, 1'b0);
      send_word(S_MAX, 1'b1, 1'b0);
      // length past the depth acts as the depth
      csr_write(mas_pkg::CSR_WLEN, 7'd127);
      send_word(S_MAX, 1'b1, 1'b0);
      send_word(S_MIN, 1'b1, 1'b0);
      send_word(S_MIN, 1'b0, 1'b0);
      csr_write(CSR_SPARE_B, 7'd0);
      send_word('0, 1'b1, 1'b1);

      // unused mode code
      csr_write(mas_pkg::CSR_MODE, {5'h1f, MODE_UNUSED});
      send_word(S_MAX, 1'b1, 1'b0);
      csr_write(mas_pkg::CSR_MODE, {5'd0, mas_pkg::MODE_SMA});
      csr_write(mas_pkg::CSR_WLEN, 7'd64);
      send_word(S_MIN, 1'b1, 1'b0);
      send_word(S_MIN, 1'b1, 1'b0);

      // random phases, each with fresh settings
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         phase++;
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0)
            csr_write($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, 7'($urandom));
         r = $urandom_range(0, 9);
         if (r < 4) m = mas_pkg::MODE_SMA;
         else if (r < 8) m = mas_pkg::MODE_EMA;
         else if (r == 8) m = mas_pkg::MODE_PASS;
         else m = MODE_UNUSED;
         csr_write(mas_pkg::CSR_MODE, {5'($urandom), m});
         r = $urandom_range(0, 9);
         if (r == 0) wl = 7'd0;
         else if (r == 1) wl = 7'd1;
         else if (r == 2) wl = 7'd64;
         else if (r == 3) wl = 7'($urandom_range(65, 127));
         else if (r < 7) wl = 7'($urandom_range(2, 8));
         else wl = 7'($urandom_range(1, 64));
         csr_write(mas_pkg::CSR_WLEN, wl);
         len = $urandom_range(8, 48);
         for (int i = 0; i < len; i++) begin
            // long receiver hold-off while words keep coming
            if (phase == 3 && i == len / 2) hold_req = 1'b1;
            // sender pause until everything has come back
            if (phase == 5 && i == len / 2) drain_results();
            r = $urandom_range(0, 9);
            if (r == 0) begin
               case ($urandom_range(0, 3))
                  0: s = S_MIN;
                  1: s = S_MAX;
                  2: s = '0;
                  default: s = -1;
               endcase
            end else if (r < 5) begin
               s = $urandom;
            end else begin
               s = last_sample + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            end
            adv = ($urandom_range(0, 5) != 0);
            rs  = ($urandom_range(0, 19) == 0);
            send_word(s, adv, rs);
            last_sample = s;
            sent++;
            sender_gap();
         end
      end

      // wind down
      calm = 1'b0;
      drain_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
